### hdl/msa_pkg.sv
`default_nettype none

// Shared types and codes for the mark-sweep slot allocator.
package msa_pkg;

	// Request command codes.
	typedef enum logic [1:0] {
		CMD_ALLOC = 2'd0,
		CMD_MARK  = 2'd1,
		CMD_SWEEP = 2'd2
	} cmd_t;

	// Response status codes.
	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_EMPTY    = 2'd1,
		ST_NOT_USED = 2'd2
	} status_t;

	// Controller states.
	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_SW_RD,
		S_SW_BIT
	} msa_state_t;

	// Control handed from the controller to the response stage.
	typedef struct packed {
		logic    push;
		status_t status;
	} rsp_ctl_t;

endpackage

`default_nettype wire

### hdl/msa_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port, registered read data.
module msa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read; a read of the address being written returns the old data.
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

### hdl/msa_ctrl.sv
`default_nettype none

// Command sequencer: owns the free list head, the free count and the fresh
// pointer, drives the bitmap memories by read-modify-write and writes the link memory.
module msa_ctrl #(
	parameter int SLOTS      = 512,
	parameter int WORD_BITS  = 32,
	parameter int IDXW       = $clog2(SLOTS),
	parameter int CNTW       = $clog2(SLOTS + 1),
	parameter int WORD_COUNT = (SLOTS + WORD_BITS - 1) / WORD_BITS,
	parameter int ROW_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,

	// Request side.
	input  wire logic                 cmd_valid,
	output logic                      cmd_ready,
	input  wire logic [1:0]           command,
	input  wire logic [IDXW-1:0]      slot_index,

	// Response stage.
	input  wire logic                 skid_full,
	output msa_pkg::rsp_ctl_t         rsp_ctl,
	output logic      [IDXW-1:0]      push_given,
	output logic      [CNTW-1:0]      push_total,

	// Used and mark bitmaps share their addresses.
	output logic      [ROW_W-1:0]     bm_raddr,
	output logic      [ROW_W-1:0]     bm_waddr,
	output logic                      used_we,
	output logic      [WORD_BITS-1:0] used_wdata,
	input  wire logic [WORD_BITS-1:0] used_rdata,
	output logic                      mark_we,
	output logic      [WORD_BITS-1:0] mark_wdata,
	input  wire logic [WORD_BITS-1:0] mark_rdata,

	// Free list links.
	output logic      [IDXW-1:0]      link_raddr,
	output logic                      link_we,
	output logic      [IDXW-1:0]      link_waddr,
	output logic      [CNTW-1:0]      link_wdata,
	input  wire logic [CNTW-1:0]      link_rdata
);

	import msa_pkg::*;

	// WORD_BITS is a power of two, so a slot splits into row and bit fields.
	localparam int BIT_W = $clog2(WORD_BITS);
	localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(WORD_COUNT - 1);
	localparam logic [BIT_W-1:0] BIT_LAST = BIT_W'(WORD_BITS - 1);
	localparam logic [CNTW-1:0]  SLOTS_C  = CNTW'(SLOTS);

	msa_state_t      state_q, state_d;
	logic [ROW_W-1:0] row_q, row_d;
	logic [BIT_W-1:0] bit_q, bit_d;
	logic [CNTW-1:0]  head_q, head_d;
	logic [CNTW-1:0]  total_q, total_d;
	logic [CNTW-1:0]  fresh_q, fresh_d;
	logic [1:0]       cmd_q;
	logic [IDXW-1:0]  idx_q;

	logic [ROW_W-1:0]     in_row, head_row, idx_row;
	logic [BIT_W-1:0]     head_bit, idx_bit;
	logic [IDXW-1:0]      sweep_slot;
	logic                 fresh_hit;
	logic                 idx_over;
	logic                 slot_free;

	// Address fields of the slots in play.
	assign in_row     = ROW_W'(slot_index >> BIT_W);
	assign head_row   = ROW_W'(head_q >> BIT_W);
	assign head_bit   = BIT_W'(head_q);
	assign idx_row    = ROW_W'(idx_q >> BIT_W);
	assign idx_bit    = BIT_W'(idx_q);
	assign sweep_slot = IDXW'({row_q, bit_q});

	// Slots at or above the fresh pointer were never pushed, so their link is
	// simply the next slot and the link memory holds nothing for them.
	assign fresh_hit = (head_q == fresh_q);
	assign idx_over  = (CNTW'(idx_q) >= SLOTS_C);
	assign slot_free = used_rdata[bit_q] && !mark_rdata[bit_q];

	assign link_raddr = IDXW'(head_q);
	assign push_total = total_d;

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// Pool bookkeeping registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q   <= '0;
			bit_q   <= '0;
			head_q  <= '0;
			total_q <= SLOTS_C;
			fresh_q <= '0;
		end else begin
			row_q   <= row_d;
			bit_q   <= bit_d;
			head_q  <= head_d;
			total_q <= total_d;
			fresh_q <= fresh_d;
		end
	end

	// Request fields captured at accept.
	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready) begin
			cmd_q <= command;
			idx_q <= slot_index;
		end
	end

	// Next state, memory accesses and the response.
	always_comb begin
		state_d        = state_q;
		row_d          = row_q;
		bit_d          = bit_q;
		head_d         = head_q;
		total_d        = total_q;
		fresh_d        = fresh_q;
		cmd_ready      = 1'b0;
		rsp_ctl.push   = 1'b0;
		rsp_ctl.status = ST_OK;
		push_given     = '0;
		bm_raddr       = row_q;
		bm_waddr       = row_q;
		used_we        = 1'b0;
		used_wdata     = used_rdata;
		mark_we        = 1'b0;
		mark_wdata     = mark_rdata;
		link_we        = 1'b0;
		link_waddr     = sweep_slot;
		link_wdata     = head_q;

		unique case (state_q)
			// Zero both bitmaps one row per cycle after reset.
			S_CLEAR: begin
				used_we    = 1'b1;
				mark_we    = 1'b1;
				used_wdata = '0;
				mark_wdata = '0;
				if (row_q == ROW_LAST) begin
					row_d   = '0;
					state_d = S_IDLE;
				end else begin
					row_d = row_q + 1'b1;
				end
			end

			// Take a request and start the bitmap read it needs.
			S_IDLE: begin
				cmd_ready = !skid_full;
				bm_raddr  = (command == CMD_MARK) ? in_row : head_row;
				if (cmd_valid && cmd_ready) begin
					if (command == CMD_SWEEP) begin
						row_d   = '0;
						state_d = S_SW_RD;
					end else begin
						state_d = S_EXEC;
					end
				end
			end

			// Allocate, mark or ignore, with the read data now at hand.
			S_EXEC: begin
				rsp_ctl.push = 1'b1;
				state_d      = S_IDLE;
				case (cmd_q)
					CMD_ALLOC: begin
						if (total_q == '0) begin
							rsp_ctl.status = ST_EMPTY;
						end else begin
							push_given = IDXW'(head_q);
							bm_waddr   = head_row;
							used_we    = 1'b1;
							used_wdata = used_rdata | (WORD_BITS'(1) << head_bit);
							total_d    = total_q - 1'b1;
							if (fresh_hit) begin
								head_d  = head_q + 1'b1;
								fresh_d = fresh_q + 1'b1;
							end else begin
								head_d = link_rdata;
							end
						end
					end
					CMD_MARK: begin
						if (idx_over || !used_rdata[idx_bit]) begin
							rsp_ctl.status = ST_NOT_USED;
						end else begin
							bm_waddr   = idx_row;
							mark_we    = 1'b1;
							mark_wdata = mark_rdata | (WORD_BITS'(1) << idx_bit);
						end
					end
					default: begin
					end
				endcase
			end

			// Sweep: fetch the next bitmap row.
			S_SW_RD: begin
				bit_d   = '0;
				state_d = S_SW_BIT;
			end

			// Sweep: one slot per cycle, row write-back on the last bit.
			S_SW_BIT: begin
				if (slot_free) begin
					link_we = 1'b1;
					head_d  = CNTW'(sweep_slot);
					if (total_q != SLOTS_C) begin
						total_d = total_q + 1'b1;
					end
				end
				if (bit_q == BIT_LAST) begin
					used_we    = 1'b1;
					mark_we    = 1'b1;
					used_wdata = used_rdata & mark_rdata;
					mark_wdata = mark_rdata & ~used_rdata;
					if (row_q == ROW_LAST) begin
						rsp_ctl.push = 1'b1;
						row_d        = '0;
						state_d      = S_IDLE;
					end else begin
						row_d   = row_q + 1'b1;
						state_d = S_SW_RD;
					end
				end else begin
					bit_d = bit_q + 1'b1;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

### hdl/msa_rsp.sv
`default_nettype none

// Response register with one skid entry, so a finished response can wait
// while the controller takes the next request.
module msa_rsp #(
	parameter int SLOTS = 512,
	parameter int IDXW  = $clog2(SLOTS),
	parameter int CNTW  = $clog2(SLOTS + 1)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire msa_pkg::rsp_ctl_t rsp_ctl,
	input  wire logic [IDXW-1:0]   push_given,
	input  wire logic [CNTW-1:0]   push_total,
	output logic                   skid_full,
	output logic                   rsp_valid,
	input  wire logic              rsp_stall,
	output logic      [IDXW-1:0]   slot_given,
	output logic      [1:0]        status,
	output logic      [CNTW-1:0]   free_slots,
	output logic                   pool_all_free
);

	import msa_pkg::*;

	localparam logic [CNTW-1:0] SLOTS_C = CNTW'(SLOTS);

	logic            out_valid_q, skid_valid_q;
	logic            out_free;
	logic            push_all_free;
	logic [IDXW-1:0] out_given_q, skid_given_q;
	status_t         out_status_q, skid_status_q;
	logic [CNTW-1:0] out_total_q, skid_total_q;
	logic            out_all_q, skid_all_q;

	assign out_free      = !out_valid_q || !rsp_stall;
	assign push_all_free = (push_total == SLOTS_C);
	assign skid_full     = skid_valid_q;

	// Occupancy of the output and skid entries.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || rsp_ctl.push;
			skid_valid_q <= 1'b0;
		end else if (rsp_ctl.push) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Payload: the skid entry drains first, a new push only lands in an empty slot.
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (skid_valid_q) begin
				out_given_q  <= skid_given_q;
				out_status_q <= skid_status_q;
				out_total_q  <= skid_total_q;
				out_all_q    <= skid_all_q;
			end else if (rsp_ctl.push) begin
				out_given_q  <= push_given;
				out_status_q <= rsp_ctl.status;
				out_total_q  <= push_total;
				out_all_q    <= push_all_free;
			end
		end else if (rsp_ctl.push) begin
			skid_given_q  <= push_given;
			skid_status_q <= rsp_ctl.status;
			skid_total_q  <= push_total;
			skid_all_q    <= push_all_free;
		end
	end

	assign rsp_valid     = out_valid_q;
	assign slot_given    = out_given_q;
	assign status        = out_status_q;
	assign free_slots    = out_total_q;
	assign pool_all_free = out_all_q;

endmodule

`default_nettype wire

### hdl/mark_sweep_slot_allocator_unit.sv
// Allocate, mark and unknown commands: the response is pushed from S_EXEC into the
// response register, or into the skid entry while the output is held; the next request
// is taken once the controller is back in S_IDLE, or later while an undelivered response
// waits in the skid entry.
// Sweep: one bitmap row read per row, then one slot per cycle; the response is pushed after the last row.
// After reset cmd_stall stays high while both bitmaps clear.
`default_nettype none

module mark_sweep_slot_allocator_unit #(
	parameter int SLOTS     = 512,
	parameter int WORD_BITS = 32
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cmd_valid,
	output logic                               cmd_stall,
	input  wire logic [1:0]                    command,
	input  wire logic [$clog2(SLOTS)-1:0]      slot_index,
	output logic                               rsp_valid,
	input  wire logic                          rsp_stall,
	output logic      [$clog2(SLOTS)-1:0]      slot_given,
	output logic      [1:0]                    status,
	output logic      [$clog2(SLOTS + 1)-1:0]  free_slots,
	output logic                               pool_all_free
);

	import msa_pkg::*;

	localparam int IDXW       = $clog2(SLOTS);
	localparam int CNTW       = $clog2(SLOTS + 1);
	localparam int WORD_COUNT = (SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int ROW_W      = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;

	logic                 cmd_ready;
	logic                 skid_full;
	rsp_ctl_t             rsp_ctl;
	logic [IDXW-1:0]      push_given;
	logic [CNTW-1:0]      push_total;
	logic [ROW_W-1:0]     bm_raddr, bm_waddr;
	logic                 used_we, mark_we;
	logic [WORD_BITS-1:0] used_wdata, used_rdata, mark_wdata, mark_rdata;
	logic [IDXW-1:0]      link_raddr, link_waddr;
	logic                 link_we;
	logic [CNTW-1:0]      link_wdata, link_rdata;

	assign cmd_stall = !cmd_ready;

	// Used bitmap, one row per WORD_BITS slots.
	msa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORD_COUNT),
		.AW    (ROW_W)
	) u_used_ram (
		.clk   (clk),
		.we    (used_we),
		.waddr (bm_waddr),
		.wdata (used_wdata),
		.raddr (bm_raddr),
		.rdata (used_rdata)
	);

	// Mark bitmap, same layout as the used bitmap.
	msa_ram #(
		.WIDTH (WORD_BITS),
		.DEPTH (WORD_COUNT),
		.AW    (ROW_W)
	) u_mark_ram (
		.clk   (clk),
		.we    (mark_we),
		.waddr (bm_waddr),
		.wdata (mark_wdata),
		.raddr (bm_raddr),
		.rdata (mark_rdata)
	);

	// Free list links, one per slot.
	msa_ram #(
		.WIDTH (CNTW),
		.DEPTH (SLOTS),
		.AW    (IDXW)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	// Command sequencer.
	msa_ctrl #(
		.SLOTS      (SLOTS),
		.WORD_BITS  (WORD_BITS),
		.IDXW       (IDXW),
		.CNTW       (CNTW),
		.WORD_COUNT (WORD_COUNT),
		.ROW_W      (ROW_W)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd_ready  (cmd_ready),
		.command    (command),
		.slot_index (slot_index),
		.skid_full  (skid_full),
		.rsp_ctl    (rsp_ctl),
		.push_given (push_given),
		.push_total (push_total),
		.bm_raddr   (bm_raddr),
		.bm_waddr   (bm_waddr),
		.used_we    (used_we),
		.used_wdata (used_wdata),
		.used_rdata (used_rdata),
		.mark_we    (mark_we),
		.mark_wdata (mark_wdata),
		.mark_rdata (mark_rdata),
		.link_raddr (link_raddr),
		.link_we    (link_we),
		.link_waddr (link_waddr),
		.link_wdata (link_wdata),
		.link_rdata (link_rdata)
	);

	// Response register and skid entry.
	msa_rsp #(
		.SLOTS (SLOTS),
		.IDXW  (IDXW),
		.CNTW  (CNTW)
	) u_rsp (
		.clk           (clk),
		.arst_n        (arst_n),
		.rsp_ctl       (rsp_ctl),
		.push_given    (push_given),
		.push_total    (push_total),
		.skid_full     (skid_full),
		.rsp_valid     (rsp_valid),
		.rsp_stall     (rsp_stall),
		.slot_given    (slot_given),
		.status        (status),
		.free_slots    (free_slots),
		.pool_all_free (pool_all_free)
	);

endmodule

`default_nettype wire

### hdl/msa_checker.sv
`default_nettype none

// Port-level checks for the slot allocator.
module msa_checker #(
	parameter int SLOTS     = 512,
	parameter int WORD_BITS = 32
) (
	input wire logic                         clk,
	input wire logic                         arst_n,
	input wire logic                         cmd_valid,
	input wire logic                         cmd_stall,
	input wire logic [1:0]                   command,
	input wire logic [$clog2(SLOTS)-1:0]     slot_index,
	input wire logic                         rsp_valid,
	input wire logic                         rsp_stall,
	input wire logic [$clog2(SLOTS)-1:0]     slot_given,
	input wire logic [1:0]                   status,
	input wire logic [$clog2(SLOTS + 1)-1:0] free_slots,
	input wire logic                         pool_all_free
);

	import msa_pkg::*;

	localparam int CNTW = $clog2(SLOTS + 1);
	localparam logic [CNTW-1:0] SLOTS_C = CNTW'(SLOTS);

	// A held response keeps its payload.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(slot_given) && $stable(status)
			&& $stable(free_slots) && $stable(pool_all_free))
		else $error("response changed while stalled");

	// The pool-free flag agrees with the free count.
	a_all_free: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> (pool_all_free == (free_slots == SLOTS_C)))
		else $error("pool_all_free disagrees with free_slots");

	// An empty report means no slot left and none handed out.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == ST_EMPTY) |-> (free_slots == '0) && (slot_given == '0))
		else $error("empty status with free slots or a slot given");

	// Every taken command leaves S_IDLE, so a taken request stalls the next.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && !cmd_stall |=> cmd_stall)
		else $error("request taken on back-to-back cycles");

	// A presented request carries a known command and slot.
	a_cmd_known: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid |-> !$isunknown({command, slot_index}))
		else $error("request with unknown command or slot");

endmodule

bind mark_sweep_slot_allocator_unit msa_checker #(
	.SLOTS     (SLOTS),
	.WORD_BITS (WORD_BITS)
) u_msa_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd_valid),
	.cmd_stall     (cmd_stall),
	.command       (command),
	.slot_index    (slot_index),
	.rsp_valid     (rsp_valid),
	.rsp_stall     (rsp_stall),
	.slot_given    (slot_given),
	.status        (status),
	.free_slots    (free_slots),
	.pool_all_free (pool_all_free)
);

`default_nettype wire

### bench/slot_pool_checker.sv
`timescale 1ns / 100ps

// Watches the request and response channels of the slot allocator, keeps a
// model of the pool and compares every response with its expected value.
module slot_pool_checker #(
	parameter int SLOTS = 512
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cmd_valid,
	input  logic                         cmd_stall,
	input  logic [1:0]                   command,
	input  logic [$clog2(SLOTS)-1:0]     slot_index,
	input  logic                         rsp_valid,
	input  logic                         rsp_stall,
	input  logic [$clog2(SLOTS)-1:0]     slot_given,
	input  logic [1:0]                   status,
	input  logic [$clog2(SLOTS + 1)-1:0] free_slots,
	input  logic                         pool_all_free,
	output int                           pending,
	output int                           errors
);

	import msa_pkg::*;

	localparam int IW = $clog2(SLOTS);
	localparam int CW = $clog2(SLOTS + 1);

	typedef struct packed {
		logic [IW-1:0] slot;
		status_t       st;
		logic [CW-1:0] free;
		logic          all_free;
	} outcome_t;

	// Pool model: used and mark maps, free list links, list head and free count.
	logic          used_map [SLOTS];
	logic          marked_map [SLOTS];
	logic [CW-1:0] link [SLOTS];
	logic [CW-1:0] head;
	logic [CW-1:0] free_cnt;

	// Responses still owed by the block, oldest first.
	outcome_t owed_q [$];

	// Apply one request to the pool model and return the response it causes.
	function automatic outcome_t serve_request(input logic [1:0] op, input logic [IW-1:0] idx);
		outcome_t o;
		int s;
		o.slot = '0;
		o.st   = ST_OK;
		case (op)
			CMD_ALLOC: begin
				if (free_cnt == 0 || head >= SLOTS) begin
					o.st = ST_EMPTY;
				end else begin
					o.slot = head[IW-1:0];
					head = link[o.slot];
					free_cnt = free_cnt - 1'b1;
					used_map[o.slot] = 1'b1;
				end
			end
			CMD_MARK: begin
				if (idx >= SLOTS || !used_map[idx])
					o.st = ST_NOT_USED;
				else
					marked_map[idx] = 1'b1;
			end
			CMD_SWEEP: begin
				// Ascending walk: survivors lose their mark, the rest go back on the list.
				for (s = 0; s < SLOTS; s++) begin
					if (used_map[s]) begin
						if (marked_map[s]) begin
							marked_map[s] = 1'b0;
						end else begin
							link[s] = head;
							head = CW'(s);
							if (free_cnt < SLOTS)
								free_cnt = free_cnt + 1'b1;
							used_map[s] = 1'b0;
						end
					end
				end
			end
			default: begin
			end
		endcase
		o.free     = free_cnt;
		o.all_free = (free_cnt == SLOTS);
		return o;
	endfunction

	task automatic check_field(input string what, input int want_v, input int got_v);
		if (want_v != got_v) begin
			errors++;
			$display("%0t: %s expected %0d actual %0d", $time, what, want_v, got_v);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		outcome_t want;
		int s;
		if (!arst_n) begin
			// Pool state after reset: every slot free, listed in ascending order.
			for (s = 0; s < SLOTS; s++) begin
				used_map[s]   = 1'b0;
				marked_map[s] = 1'b0;
				link[s]       = CW'(s + 1);
			end
			head     = '0;
			free_cnt = CW'(SLOTS);
			owed_q.delete();
			errors = 0;
			pending <= 0;
		end else begin
			// Compare an accepted response with the oldest expected one.
			if (rsp_valid && !rsp_stall) begin
				if (owed_q.size() == 0) begin
					errors++;
					$display("%0t: response with no request outstanding, slot %0d status %0d",
						$time, slot_given, status);
				end else begin
					want = owed_q.pop_front();
					check_field("slot_given", want.slot, slot_given);
					check_field("status", want.st, status);
					check_field("free_slots", want.free, free_slots);
					check_field("pool_all_free", want.all_free, pool_all_free);
				end
			end
			// Predict the response of each accepted request.
			if (cmd_valid && !cmd_stall)
				owed_q.push_back(serve_request(command, slot_index));
			pending <= owed_q.size();
		end
	end

endmodule

### bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import msa_pkg::*;

	localparam int SLOTS = 512;
	localparam int IW    = $clog2(SLOTS);
	localparam int CW    = $clog2(SLOTS + 1);

	localparam logic [1:0] CMD_UNKNOWN = 2'd3;

	localparam int RANDOM_ITEMS = 650;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int DRAIN_CYCLES = 40;

	logic          clk;
	logic          arst_n;
	logic          cmd_valid;
	logic          cmd_stall;
	logic [1:0]    command;
	logic [IW-1:0] slot_index;
	logic          rsp_valid;
	logic          rsp_stall;
	logic [IW-1:0] slot_given;
	logic [1:0]    status;
	logic [CW-1:0] free_slots;
	logic          pool_all_free;

	int pending;
	int errors;
	int cycle_count = 0;
	int item_count = 0;
	int burst_left = 0;
	bit idle_on = 1'b0;
	int stall_mode = 0;
	int stall_run = 0;

	// Slots handed out, slots believed in use, and slots marked this round.
	logic [IW-1:0] given_q [$];
	logic [IW-1:0] live_q [$];
	logic [IW-1:0] kept_q [$];

	mark_sweep_slot_allocator_unit #(
		.SLOTS(SLOTS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.command      (command),
		.slot_index   (slot_index),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.slot_given   (slot_given),
		.status       (status),
		.free_slots   (free_slots),
		.pool_all_free(pool_all_free)
	);

	slot_pool_checker #(
		.SLOTS(SLOTS)
	) u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (cmd_valid),
		.cmd_stall    (cmd_stall),
		.command      (command),
		.slot_index   (slot_index),
		.rsp_valid    (rsp_valid),
		.rsp_stall    (rsp_stall),
		.slot_given   (slot_given),
		.status       (status),
		.free_slots   (free_slots),
		.pool_all_free(pool_all_free),
		.pending      (pending),
		.errors       (errors)
	);

	// Clock with a 10 ns period.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hard stop if the run hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("[mark_sweep_slot_allocator_unit] ERROR");
			$finish;
		end
	end

	// Response stall pattern: none, short random stalls, or long on and off runs.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
			stall_run <= 0;
		end else if (stall_run > 0) begin
			stall_run <= stall_run - 1;
		end else begin
			case (stall_mode)
				0: begin
					rsp_stall <= 1'b0;
					stall_run <= $urandom_range(1, 8);
				end
				1: begin
					rsp_stall <= ($urandom_range(0, 2) == 0);
					stall_run <= 0;
				end
				default: begin
					rsp_stall <= ~rsp_stall;
					stall_run <= $urandom_range(0, 11);
				end
			endcase
		end
	end

	// Collect slots handed out so that later mark requests can aim at live slots.
	always @(posedge clk) begin
		if (rsp_valid && !rsp_stall && status == ST_OK && slot_given != '0)
			given_q.push_back(slot_given);
	end

	function automatic logic [IW-1:0] any_slot();
		return IW'($urandom_range(0, SLOTS - 1));
	endfunction

	// Send one request, wait for it to be taken, then maybe leave a gap.
	task automatic issue(input logic [1:0] op, input logic [IW-1:0] idx);
		int gap;
		command    <= op;
		slot_index <= idx;
		cmd_valid  <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		item_count++;
		if (idle_on) begin
			if (burst_left == 0) begin
				gap        = $urandom_range(1, 6);
				burst_left = $urandom_range(1, 12);
				cmd_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end else begin
				burst_left--;
			end
		end
	endtask

	// Hold off new requests until every expected response has arrived.
	task automatic drain_responses();
		cmd_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// One allocate, mark, sweep cycle with random content and some noise.
	task automatic run_round();
		int n;
		int r;
		int pick;
		idle_on     = ($urandom_range(0, 3) != 0);
		stall_mode <= $urandom_range(0, 2);
		n = $urandom_range(4, 40);
		repeat (n) issue(CMD_ALLOC, any_slot());
		while (given_q.size() > 0)
			live_q.push_back(given_q.pop_front());
		n = $urandom_range(2, 30);
		repeat (n) begin
			r = $urandom_range(0, 9);
			if (r < 7 && live_q.size() > 0) begin
				pick = $urandom_range(0, live_q.size() - 1);
				kept_q.push_back(live_q[pick]);
				issue(CMD_MARK, live_q[pick]);
			end else if (r < 9) begin
				issue(CMD_MARK, any_slot());
			end else begin
				issue(CMD_UNKNOWN, any_slot());
			end
		end
		if ($urandom_range(0, 3) == 0)
			drain_responses();
		// Now and then the round ends without a sweep.
		if ($urandom_range(0, 5) != 0) begin
			issue(CMD_SWEEP, any_slot());
			live_q = kept_q;
			kept_q.delete();
			given_q.delete();
		end
	endtask

	// Free the whole pool, then allocate past its end and collect on a full pool.
	task automatic exhaust_pool();
		idle_on     = ($urandom_range(0, 1) != 0);
		stall_mode <= $urandom_range(0, 2);
		issue(CMD_SWEEP, any_slot());
		issue(CMD_SWEEP, any_slot());
		repeat (SLOTS + 4) issue(CMD_ALLOC, any_slot());
		issue(CMD_MARK, '0);
		issue(CMD_MARK, IW'(SLOTS - 1));
		repeat (20) issue(CMD_MARK, any_slot());
		issue(CMD_ALLOC, any_slot());
		issue(CMD_SWEEP, any_slot());
		live_q.delete();
		kept_q.delete();
		given_q.delete();
	endtask

	initial begin : stimulus
		int directed_end;
		bit exhausted;
		arst_n     = 1'b0;
		cmd_valid  = 1'b0;
		command    = CMD_ALLOC;
		slot_index = '0;
		exhausted  = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Directed requests on a fresh pool with no idling on either side.
		issue(CMD_MARK, '0);
		issue(CMD_MARK, IW'(SLOTS - 1));
		issue(CMD_UNKNOWN, IW'(SLOTS - 1));
		issue(CMD_SWEEP, 9'h155);
		issue(CMD_ALLOC, IW'(SLOTS - 1));
		issue(CMD_ALLOC, 9'h0AA);
		issue(CMD_ALLOC, '0);
		issue(CMD_MARK, '0);
		issue(CMD_MARK, '0);
		issue(CMD_MARK, 9'd2);
		issue(CMD_MARK, 9'd3);
		drain_responses();
		issue(CMD_SWEEP, '0);
		issue(CMD_ALLOC, '0);
		issue(CMD_SWEEP, '0);
		issue(CMD_ALLOC, IW'(SLOTS - 1));
		issue(CMD_MARK, 9'd2);
		issue(CMD_UNKNOWN, '0);
		issue(CMD_SWEEP, IW'(SLOTS - 1));
		issue(CMD_SWEEP, 9'h0AA);
		drain_responses();
		given_q.delete();
		directed_end = item_count;

		// Random rounds, with one pass that runs the pool dry along the way.
		while (item_count < directed_end + RANDOM_ITEMS) begin
			if (!exhausted && item_count >= directed_end + 60) begin
				exhaust_pool();
				exhausted = 1'b1;
			end else begin
				run_round();
			end
		end

		drain_responses();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("[mark_sweep_slot_allocator_unit] OK");
		else
			$display("[mark_sweep_slot_allocator_unit] ERROR");
		$finish;
	end

endmodule
